@@ hdl/quaternion_arithmetic_unit_core_assert.svh @@
// Assertion macros for the quaternion arithmetic unit.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef QUATERNION_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// same-cycle implication, idle during reset
`define QAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define QAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/qau_pkg.sv @@
// Shared constants and types for the quaternion arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps

package qau_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int ACC_BITS   = 2 * WORD_BITS + 2;
    localparam int RAD_BITS   = 2 * WORD_BITS + 1;
    localparam int ROOT_BITS  = WORD_BITS + 1;
    localparam int SQ_BITS    = 2 * WORD_BITS + 3;
    localparam int QUO_BITS   = FRAC_BITS + 1;
    localparam int DIV_BITS   = WORD_BITS + FRAC_BITS + 2;
    localparam int SIDE_DEPTH = ROOT_BITS + QUO_BITS;

    localparam logic [2:0] OP_QMUL  = 3'd0;
    localparam logic [2:0] OP_VMUL  = 3'd1;
    localparam logic [2:0] OP_SCALE = 3'd2;
    localparam logic [2:0] OP_CONJ  = 3'd3;
    localparam logic [2:0] OP_NORM  = 3'd4;
    localparam logic [2:0] OP_MAG   = 3'd5;

    localparam logic signed [WORD_BITS-1:0] FX_ONE = WORD_BITS'(1) << FRAC_BITS;

    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        {{(ACC_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SAT_LO =
        {{(ACC_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [2:0]                  op;
        logic [3:0][WORD_BITS-1:0]   res;
        logic                        ovf;
        logic [3:0]                  neg;
        logic [3:0][WORD_BITS-1:0]   num;
    } t_side;

endpackage

@@ hdl/qau_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on qau_pkg.
`timescale 1ns / 1ps

module qau_sqrt (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [qau_pkg::RAD_BITS-1:0]    i_rad,
    output logic [qau_pkg::ROOT_BITS-1:0]   o_root
);

    localparam int RADB  = qau_pkg::RAD_BITS;
    localparam int ROOTB = qau_pkg::ROOT_BITS;
    localparam int SQB   = qau_pkg::SQ_BITS;

    logic [RADB-1:0]  r_rem  [ROOTB];
    logic [ROOTB-1:0] r_root [ROOTB];

    for (genvar g = 0; g < ROOTB; g++) begin : g_stage
        localparam int BIT = ROOTB - 1 - g;
        logic [RADB-1:0]  rin;
        logic [ROOTB-1:0] qin;
        logic [SQB-1:0]   remx;
        logic [SQB-1:0]   trial;

        if (g == 0) begin : g_first
            assign rin = i_rad;
            assign qin = '0;
        end else begin : g_next
            assign rin = r_rem[g-1];
            assign qin = r_root[g-1];
        end

        assign remx  = SQB'(rin);
        assign trial = (SQB'(qin) << (BIT + 1)) + (SQB'(1) << (2 * BIT));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (remx >= trial) begin
                    r_rem[g]  <= RADB'(remx - trial);
                    r_root[g] <= qin | (ROOTB'(1) << BIT);
                end else begin
                    r_rem[g]  <= rin;
                    r_root[g] <= qin;
                end
            end
        end
    end

    assign o_root = r_root[ROOTB-1];

endmodule

@@ hdl/qau_div.sv @@
// Four-lane pipelined restoring divider with a shared divisor.
// Depends on qau_pkg.
`timescale 1ns / 1ps

module qau_div (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [qau_pkg::WORD_BITS-1:0]   i_num [4],
    input  logic [qau_pkg::ROOT_BITS-1:0]   i_den,
    output logic [qau_pkg::QUO_BITS-1:0]    o_quo [4],
    output logic [qau_pkg::ROOT_BITS-1:0]   o_den
);

    localparam int F   = qau_pkg::FRAC_BITS;
    localparam int QB  = qau_pkg::QUO_BITS;
    localparam int DB  = qau_pkg::DIV_BITS;
    localparam int RB  = qau_pkg::ROOT_BITS;

    logic [DB-1:0] r_rem [QB][4];
    logic [QB-1:0] r_quo [QB][4];
    logic [RB-1:0] r_den [QB];

    for (genvar g = 0; g < QB; g++) begin : g_stage
        localparam int SH = QB - 1 - g;
        logic [DB-1:0] rin [4];
        logic [QB-1:0] qin [4];
        logic [RB-1:0] din;
        logic [DB-1:0] trial;

        if (g == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < 4; l++) begin
                    rin[l] = DB'({i_num[l], {F{1'b0}}});
                    qin[l] = '0;
                end
            end
            assign din = i_den;
        end else begin : g_next
            always_comb begin
                for (int l = 0; l < 4; l++) begin
                    rin[l] = r_rem[g-1][l];
                    qin[l] = r_quo[g-1][l];
                end
            end
            assign din = r_den[g-1];
        end

        assign trial = DB'(din) << SH;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g] <= din;
                for (int l = 0; l < 4; l++) begin
                    if (rin[l] >= trial) begin
                        r_rem[g][l] <= rin[l] - trial;
                        r_quo[g][l] <= qin[l] | (QB'(1) << SH);
                    end else begin
                        r_rem[g][l] <= rin[l];
                        r_quo[g][l] <= qin[l];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            o_quo[l] = r_quo[QB-1][l];
        end
    end
    assign o_den = r_den[QB-1];

endmodule

@@ hdl/quaternion_arithmetic_unit_core.sv @@
// Quaternion arithmetic unit: products, scale, conjugate, normalize, magnitude.
// Depends on qau_pkg, qau_sqrt, qau_div and quaternion_arithmetic_unit_core_assert.svh.
//
//   channel  | dir | handshake          | payload
//   request  | in  | i_valid / o_stall  | i_req_type, i_a_*, i_b_*, i_scale
//   result   | out | o_valid / i_stall  | o_r_*, o_magnitude, o_overflow, o_zero_magnitude
//
// One word accepted per cycle while the pipeline is not stalled; operands are Q16.16,
// and the square root and divider resolve one result bit per stage.
// All stages advance together; a held output word stalls the whole pipeline,
// empty stages included, so bubbles are not squeezed out.
// Synchronous active-low reset clears only the valid bits.
`timescale 1ns / 1ps

`include "quaternion_arithmetic_unit_core_assert.svh"

module quaternion_arithmetic_unit_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [2:0]                              i_req_type,
    input  logic signed [qau_pkg::WORD_BITS-1:0]    i_a_x,
    input  logic signed [qau_pkg::WORD_BITS-1:0]    i_a_y,
    input  logic signed [qau_pkg::WORD_BITS-1:0]    i_a_z,
    input  logic signed [qau_pkg::WORD_BITS-1:0]    i_a_w,
    input  logic signed [qau_pkg::WORD_BITS-1:0]    i_b_x,
    input  logic signed [qau_pkg::WORD_BITS-1:0]    i_b_y,
    input  logic signed [qau_pkg::WORD_BITS-1:0]    i_b_z,
    input  logic signed [qau_pkg::WORD_BITS-1:0]    i_b_w,
    input  logic signed [qau_pkg::WORD_BITS-1:0]    i_scale,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [qau_pkg::WORD_BITS-1:0]    o_r_x,
    output logic signed [qau_pkg::WORD_BITS-1:0]    o_r_y,
    output logic signed [qau_pkg::WORD_BITS-1:0]    o_r_z,
    output logic signed [qau_pkg::WORD_BITS-1:0]    o_r_w,
    output logic [qau_pkg::WORD_BITS-1:0]           o_magnitude,
    output logic                                    o_overflow,
    output logic                                    o_zero_magnitude
);

    localparam int W    = qau_pkg::WORD_BITS;
    localparam int F    = qau_pkg::FRAC_BITS;
    localparam int PB   = qau_pkg::PROD_BITS;
    localparam int AB   = qau_pkg::ACC_BITS;
    localparam int RADB = qau_pkg::RAD_BITS;
    localparam int RB   = qau_pkg::ROOT_BITS;
    localparam int QB   = qau_pkg::QUO_BITS;
    localparam int SD   = qau_pkg::SIDE_DEPTH;

    logic adv;

    // stage A: input
    logic                r_a_vld;
    logic [2:0]          r_a_op;
    logic signed [W-1:0] r_a_a [4];
    logic signed [W-1:0] r_a_b [4];
    logic signed [W-1:0] r_a_sc;

    // stage B: products
    logic                 r_b_vld;
    logic [2:0]           r_b_op;
    logic signed [W-1:0]  r_b_a [4];
    logic signed [PB-1:0] r_b_p [4][4];
    logic                 r_b_sub [4][4];

    // stage C: sums
    logic                 r_c_vld;
    logic [2:0]           r_c_op;
    logic signed [W-1:0]  r_c_a [4];
    logic signed [AB-1:0] r_c_acc [4];

    // stage D: truncating shift, saturation and radicand
    logic                 r_d_vld;
    logic [RADB-1:0]      r_d_rad;
    qau_pkg::t_side       r_d_side;

    logic                 r_sv [SD];
    qau_pkg::t_side       r_sd [SD];

    // stage E: output
    logic                 r_e_vld;
    logic [3:0][W-1:0]    r_e_r;
    logic [W-1:0]         r_e_mag;
    logic                 r_e_ovf;
    logic                 r_e_zero;

    logic signed [W-1:0]  m1 [4][4];
    logic signed [W-1:0]  m2 [4][4];
    logic                 sub [4][4];
    logic signed [W-1:0]  bwv;
    logic signed [AB-1:0] n_acc [4];
    logic signed [AB-1:0] pe;
    logic signed [AB-1:0] sh;
    logic [RADB-1:0]      n_rad;
    qau_pkg::t_side       n_side;

    logic [RB-1:0]        sq_root;
    logic [W-1:0]         dv_num [4];
    logic [QB-1:0]        dv_quo [4];
    logic [RB-1:0]        dv_den;

    qau_pkg::t_side       fin;
    logic [3:0][W-1:0]    n_r;
    logic [W-1:0]         n_mag;
    logic                 n_ovf;
    logic                 n_zero;
    logic [W-1:0]         q;

    assign adv     = !r_e_vld || !i_stall;
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= i_valid;
        end
        if (adv) begin
            r_a_op   <= i_req_type;
            r_a_a[0] <= i_a_x;
            r_a_a[1] <= i_a_y;
            r_a_a[2] <= i_a_z;
            r_a_a[3] <= i_a_w;
            r_a_b[0] <= i_b_x;
            r_a_b[1] <= i_b_y;
            r_a_b[2] <= i_b_z;
            r_a_b[3] <= i_b_w;
            r_a_sc   <= i_scale;
        end
    end

    // operand routing: slot [component][term]
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                m1[c][k]  = '0;
                m2[c][k]  = '0;
                sub[c][k] = 1'b0;
            end
        end
        bwv = (r_a_op == qau_pkg::OP_VMUL) ? '0 : r_a_b[3];
        case (r_a_op)
            qau_pkg::OP_QMUL, qau_pkg::OP_VMUL: begin
                m1[0][0] = r_a_a[0]; m2[0][0] = bwv;
                m1[0][1] = r_a_a[3]; m2[0][1] = r_a_b[0];
                m1[0][2] = r_a_a[1]; m2[0][2] = r_a_b[2];
                m1[0][3] = r_a_a[2]; m2[0][3] = r_a_b[1]; sub[0][3] = 1'b1;
                m1[1][0] = r_a_a[1]; m2[1][0] = bwv;
                m1[1][1] = r_a_a[3]; m2[1][1] = r_a_b[1];
                m1[1][2] = r_a_a[2]; m2[1][2] = r_a_b[0];
                m1[1][3] = r_a_a[0]; m2[1][3] = r_a_b[2]; sub[1][3] = 1'b1;
                m1[2][0] = r_a_a[2]; m2[2][0] = bwv;
                m1[2][1] = r_a_a[3]; m2[2][1] = r_a_b[2];
                m1[2][2] = r_a_a[0]; m2[2][2] = r_a_b[1];
                m1[2][3] = r_a_a[1]; m2[2][3] = r_a_b[0]; sub[2][3] = 1'b1;
                m1[3][0] = r_a_a[3]; m2[3][0] = bwv;
                m1[3][1] = r_a_a[0]; m2[3][1] = r_a_b[0]; sub[3][1] = 1'b1;
                m1[3][2] = r_a_a[1]; m2[3][2] = r_a_b[1]; sub[3][2] = 1'b1;
                m1[3][3] = r_a_a[2]; m2[3][3] = r_a_b[2]; sub[3][3] = 1'b1;
            end
            qau_pkg::OP_SCALE: begin
                for (int c = 0; c < 4; c++) begin
                    m1[c][0] = r_a_a[c];
                    m2[c][0] = r_a_sc;
                end
            end
            qau_pkg::OP_CONJ: begin
                for (int c = 0; c < 3; c++) begin
                    m1[c][0] = r_a_a[c];
                    m2[c][0] = -qau_pkg::FX_ONE;
                end
                m1[3][0] = r_a_a[3];
                m2[3][0] = qau_pkg::FX_ONE;
            end
            qau_pkg::OP_NORM, qau_pkg::OP_MAG: begin
                for (int k = 0; k < 4; k++) begin
                    m1[0][k] = r_a_a[k];
                    m2[0][k] = r_a_a[k];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (adv) begin
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
        if (adv) begin
            r_b_op <= r_a_op;
            r_c_op <= r_b_op;
            for (int c = 0; c < 4; c++) begin
                r_b_a[c]   <= r_a_a[c];
                r_c_a[c]   <= r_b_a[c];
                r_c_acc[c] <= n_acc[c];
                for (int k = 0; k < 4; k++) begin
                    r_b_p[c][k]   <= m1[c][k] * m2[c][k];
                    r_b_sub[c][k] <= sub[c][k];
                end
            end
            r_d_rad  <= n_rad;
            r_d_side <= n_side;
        end
    end

    always_comb begin
        pe = '0;
        for (int c = 0; c < 4; c++) begin
            n_acc[c] = '0;
            for (int k = 0; k < 4; k++) begin
                pe = {{(AB-PB){r_b_p[c][k][PB-1]}}, r_b_p[c][k]};
                n_acc[c] = r_b_sub[c][k] ? n_acc[c] - pe : n_acc[c] + pe;
            end
        end
    end

    always_comb begin
        sh          = '0;
        n_side      = '0;
        n_side.op   = r_c_op;
        n_rad       = '0;
        for (int c = 0; c < 4; c++) begin
            n_side.neg[c] = r_c_a[c][W-1];
            n_side.num[c] = r_c_a[c][W-1] ? W'(-r_c_a[c]) : W'(r_c_a[c]);
        end
        if (r_c_op == qau_pkg::OP_NORM || r_c_op == qau_pkg::OP_MAG) begin
            n_rad = r_c_acc[0][RADB-1:0];
        end else begin
            for (int c = 0; c < 4; c++) begin
                sh = r_c_acc[c] >>> F;
                if (sh > qau_pkg::SAT_HI) begin
                    n_side.res[c] = {1'b0, {(W-1){1'b1}}};
                    n_side.ovf    = 1'b1;
                end else if (sh < qau_pkg::SAT_LO) begin
                    n_side.res[c] = {1'b1, {(W-1){1'b0}}};
                    n_side.ovf    = 1'b1;
                end else begin
                    n_side.res[c] = sh[W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SD; i++) begin
                r_sv[i] <= 1'b0;
            end
        end else if (adv) begin
            r_sv[0] <= r_d_vld;
            for (int i = 1; i < SD; i++) begin
                r_sv[i] <= r_sv[i-1];
            end
        end
        if (adv) begin
            r_sd[0] <= r_d_side;
            for (int i = 1; i < SD; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
        end
    end

    qau_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_rad  (r_d_rad),
        .o_root (sq_root)
    );

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            dv_num[c] = r_sd[RB-1].num[c];
        end
    end

    qau_div u_div (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_num  (dv_num),
        .i_den  (sq_root),
        .o_quo  (dv_quo),
        .o_den  (dv_den)
    );

    always_comb begin
        fin    = r_sd[SD-1];
        n_r    = fin.res;
        n_ovf  = fin.ovf;
        n_mag  = '0;
        n_zero = 1'b0;
        q      = '0;
        if (fin.op == qau_pkg::OP_NORM || fin.op == qau_pkg::OP_MAG) begin
            n_mag = dv_den[W] ? '1 : dv_den[W-1:0];
            n_ovf = dv_den[W];
        end
        if (fin.op == qau_pkg::OP_NORM) begin
            if (dv_den == '0) begin
                n_zero = 1'b1;
                n_r    = '0;
            end else begin
                for (int c = 0; c < 4; c++) begin
                    q      = W'(dv_quo[c]);
                    n_r[c] = fin.neg[c] ? -q : q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (adv) begin
            r_e_vld <= r_sv[SD-1];
        end
        if (adv) begin
            r_e_r    <= n_r;
            r_e_mag  <= n_mag;
            r_e_ovf  <= n_ovf;
            r_e_zero <= n_zero;
        end
    end

    assign o_valid          = r_e_vld;
    assign o_r_x            = r_e_r[0];
    assign o_r_y            = r_e_r[1];
    assign o_r_z            = r_e_r[2];
    assign o_r_w            = r_e_r[3];
    assign o_magnitude      = r_e_mag;
    assign o_overflow       = r_e_ovf;
    assign o_zero_magnitude = r_e_zero;

    `QAU_ASSERT_NOW(a_stall_cause, o_stall, o_valid && i_stall, "stall without held word")
    `QAU_ASSERT_NOW(a_zero_clear, o_valid && o_zero_magnitude, o_r_x == '0 && o_r_y == '0 && o_r_z == '0 && o_r_w == '0 && o_magnitude == '0 && !o_overflow, "zero magnitude word not clear")
    `QAU_ASSERT_NEXT(a_hold_out, o_valid && i_stall, o_valid && $stable(o_magnitude) && $stable(o_r_x), "held word changed")

endmodule
